[sv/lds_pkg.sv]
// Package for the luma 2x2 downscaler: sizes, register indexes, the command
// type that passes from the front part to the back part, and a clamp helper.
// Used by every module of the block but lds_ram; depends on nothing.
package lds_pkg;

    // Largest supported frame width in pixels.
    localparam int MAX_WIDTH    = 4096;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int STORE_DEPTH  = (MAX_WIDTH + 1) / 2;

    localparam int DIM_W  = 13;
    localparam int PIX_W  = 8;
    localparam int PAIR_W = PIX_W + 1;
    localparam int SUM_W  = PIX_W + 2;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
    localparam int IDX_W  = $clog2(STORE_DEPTH);
    localparam int HROW_W = ROW_W - 1;

    // Command queue depth; must be a power of two so the pointers wrap.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Reset geometry.
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // One pair sum on its way to the line store.
    typedef struct packed {
        logic              emit;   // odd row: read, add and output
        logic [IDX_W-1:0]  idx;
        logic [PAIR_W-1:0] pair;
        logic              last;   // last output of the frame
    } t_cmd;

    // Clamps a written dimension to the range 2..hi.
    function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int hi);
        int val;
        val = int'(v);
        if (val < 2) begin
            return 2;
        end
        if (val > hi) begin
            return hi;
        end
        return val;
    endfunction

endpackage

[sv/lds_ram.sv]
// Generic single-port RAM with registered read data.
// Stand-alone; used for the line store of pair sums.
module lds_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data holds when no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/lds_front.sv]
// Front part of the downscaler: geometry registers, raster counters and
// horizontal pair forming. Depends on lds_pkg.
module lds_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lds_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    input  logic [lds_pkg::PIX_W-1:0]     i_pixel_in,
    input  logic                          i_full,
    output logic                          o_stall,
    output logic                          o_push,
    output lds_pkg::t_cmd                 o_cmd
);
    import lds_pkg::*;

    logic [COL_W-1:0]  r_width_m1;
    logic [IDX_W-1:0]  r_half_w_m1;
    logic [ROW_W-1:0]  r_height_m1;
    logic [HROW_W-1:0] r_half_h_m1;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [PIX_W-1:0]  r_first;

    logic accept;
    int   w_clamped;
    int   h_clamped;

    assign accept    = i_valid && !i_full;
    assign o_stall   = i_full;
    assign w_clamped = clamp_dim(i_cfg_data, MAX_WIDTH);
    assign h_clamped = clamp_dim(i_cfg_data, HEIGHT_LIMIT);

    // Geometry is clamped once when written and kept as last positions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_m1  <= COL_W'(RESET_WIDTH - 1);
            r_half_w_m1 <= IDX_W'(RESET_WIDTH / 2 - 1);
            r_height_m1 <= ROW_W'(RESET_HEIGHT - 1);
            r_half_h_m1 <= HROW_W'(RESET_HEIGHT / 2 - 1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    r_width_m1  <= COL_W'(w_clamped - 1);
                    r_half_w_m1 <= IDX_W'(w_clamped / 2 - 1);
                end
                CFG_FRAME_HEIGHT: begin
                    r_height_m1 <= ROW_W'(h_clamped - 1);
                    r_half_h_m1 <= HROW_W'(h_clamped / 2 - 1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (r_col >= r_width_m1) begin
                r_col <= '0;
                r_row <= (r_row >= r_height_m1) ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
        end else if (accept && !r_col[0]) begin
            r_first <= i_pixel_in;
        end
    end

    // An odd column completes a horizontal pair.
    assign o_push     = accept && r_col[0];
    assign o_cmd.emit = r_row[0];
    assign o_cmd.idx  = IDX_W'(r_col >> 1);
    assign o_cmd.pair = PAIR_W'(r_first) + PAIR_W'(i_pixel_in);
    assign o_cmd.last = (IDX_W'(r_col >> 1) == r_half_w_m1) &&
                        (r_row[ROW_W-1:1] == r_half_h_m1);

endmodule

[sv/lds_queue.sv]
// Short command queue between the front and back parts of the downscaler.
// Depends on lds_pkg.
module lds_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lds_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output lds_pkg::t_cmd o_cmd
);
    import lds_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/lds_back.sv]
// Back part of the downscaler: line store access, vertical sum and the
// output register. Depends on lds_pkg and lds_ram.
module lds_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  lds_pkg::t_cmd             i_cmd,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [lds_pkg::PIX_W-1:0] o_pixel_out,
    output logic                      o_frame_last
);
    import lds_pkg::*;

    logic              r_s1_valid;
    logic [PAIR_W-1:0] r_s1_pair;
    logic              r_s1_last;
    logic              r_o_valid;
    logic [PIX_W-1:0]  r_o_pixel;
    logic              r_o_last;

    logic              out_ready;
    logic              s1_adv;
    logic              pop_ok;
    logic              ram_we;
    logic              ram_re;
    logic [PAIR_W-1:0] ram_rdata;
    logic [SUM_W-1:0]  sum;

    assign out_ready = !r_o_valid || !i_stall;
    assign s1_adv    = r_s1_valid && out_ready;
    assign pop_ok    = !r_s1_valid || out_ready;
    assign o_pop     = i_cmd_valid && pop_ok;
    assign ram_we    = o_pop && !i_cmd.emit;
    assign ram_re    = o_pop && i_cmd.emit;

    lds_ram #(
        .WIDTH(PAIR_W),
        .DEPTH(STORE_DEPTH)
    ) u_line_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_re   (ram_re),
        .i_addr (i_cmd.idx),
        .i_wdata(i_cmd.pair),
        .o_rdata(ram_rdata)
    );

    assign sum = SUM_W'(ram_rdata) + SUM_W'(r_s1_pair);

    // Stage one waits for the read data; it holds while the output stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pop_ok) begin
            r_s1_valid <= ram_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_s1_pair <= i_cmd.pair;
            r_s1_last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_pixel <= sum[SUM_W-1:2];
            r_o_last  <= r_s1_last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_pixel_out  = r_o_pixel;
    assign o_frame_last = r_o_last;

endmodule

[sv/luma_downscale_by_two_top.sv]
// Top level of the luma 2x2 box-filter downscaler.
// Depends on lds_pkg, lds_front, lds_queue, lds_back and lds_ram.
//
// The block takes 8-bit luma pixels in raster order and gives one pixel
// for each 2x2 block of the frame, the four-pixel sum shifted right by two
// (truncating); an odd last column or row is dropped and the last output
// of each frame carries frame_last. It accepts one pixel per clock cycle
// for as long as the output side keeps up. An output is registered in turn
// in the command queue, by the line store read and in the output register
// after the pixel that completes its block. The pixel rate is set by the
// single-port line store, which sees exactly one write or one read per
// pixel pair. Frame width and height are written through the
// configuration port (index 0 width, index 1 height, reset 640 by 480,
// values clamped to 2..4096) and must only be written while the block is
// idle. The line store holds one pair sum per column pair, is not cleared
// after reset and needs no clearing pass: each entry is written on an even
// row before the following odd row reads it. Stall on the output is felt
// at the input only once the four-entry command queue has filled.
module luma_downscale_by_two_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [lds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lds_pkg::DIM_W-1:0]     i_cfg_data,
    // Pixel input channel.
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [lds_pkg::PIX_W-1:0]     i_pixel_in,
    // Reduced pixel output channel.
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [lds_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                          o_frame_last
);
    import lds_pkg::*;

    logic q_full;
    logic q_push;
    t_cmd q_in_cmd;
    logic q_pop;
    logic q_valid;
    t_cmd q_out_cmd;

    // The front part counts positions and forms horizontal pair sums.
    lds_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .i_pixel_in (i_pixel_in),
        .i_full     (q_full),
        .o_stall    (o_stall),
        .o_push     (q_push),
        .o_cmd      (q_in_cmd)
    );

    // The queue lets the input carry on while the output is briefly held.
    lds_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (q_in_cmd),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_cmd  (q_out_cmd)
    );

    // The back part stores even-row pairs and completes odd-row blocks.
    lds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_out_cmd),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel_out (o_pixel_out),
        .o_frame_last(o_frame_last)
    );

endmodule
